/* hdl/csc_pkg.sv */
// Crystal stability checker: shared types, field widths and codes.
// No dependencies; imported by the interfaces and every module.
package csc_pkg;

   // Fixed field widths of the transaction payloads
   localparam int COUNT_W   = 32;
   localparam int TOL_W     = 16;
   localparam int MIN_W     = 8;
   localparam int SAMPLE_W  = 8;
   localparam int RUN_W     = 9;
   localparam int VERDICT_W = 2;

   // Q15 scaling of the tolerance
   localparam int Q15_SHIFT = 15;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SAMPLE = 2'd2;

   localparam logic [MIN_W-1:0]    MIN_RUN_RESET    = 8'd0;
   localparam logic [TOL_W-1:0]    TOLERANCE_RESET  = 16'd0;
   localparam logic [SAMPLE_W-1:0] MAX_SAMPLE_RESET = 8'd255;

   // Verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_MEASURING = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_STABLE    = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_TIMEOUT   = 2'd2;

   // Saturation limits
   localparam logic [RUN_W-1:0]    RUN_MAX    = '1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   typedef struct packed {
      logic [TOL_W-1:0]    tolerance_q15;
      logic [MIN_W-1:0]    min_stable_run;
      logic [SAMPLE_W-1:0] max_samples;
   } cfg_type;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [RUN_W-1:0]     run_length;
      logic [COUNT_W-1:0]   measured_period;
   } result_type;

endpackage

/* hdl/csc_req_if.sv */
// Request channel of the crystal stability checker: one timer sample.
// Depends on csc_pkg.
interface csc_req_if import csc_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] timer_count;

   modport source (output valid, output timer_count, input ready);
   modport sink   (input valid, input timer_count, output ready);
endinterface

/* hdl/csc_rsp_if.sv */
// Response channel of the crystal stability checker: verdict and period.
// Depends on csc_pkg.
interface csc_rsp_if import csc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;
   logic [RUN_W-1:0]     run_length;
   logic [COUNT_W-1:0]   measured_period;

   modport source (output valid, output verdict, output run_length,
                   output measured_period, input ready);
   modport sink   (input valid, input verdict, input run_length,
                   input measured_period, output ready);
endinterface

/* hdl/csc_core.sv */
// Measurement state and per-sample update: period, tolerance check, run and verdict.
// Depends on csc_pkg.
module csc_core import csc_pkg::*; #(
   parameter int TIMER_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  step,
   input  logic [TIMER_BITS-1:0] count,
   output result_type            res
);

   localparam int PROD_W = TIMER_BITS + TOL_W;
   localparam int LIM_W  = PROD_W - Q15_SHIFT;

   logic [TIMER_BITS-1:0] prev_ff, prev_in;
   logic [TIMER_BITS-1:0] ref_ff, ref_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [SAMPLE_W-1:0]   samples_ff, samples_in;
   logic [VERDICT_W-1:0]  verdict_ff, verdict_in;

   logic [TIMER_BITS-1:0] period;
   logic [TIMER_BITS-1:0] diff;
   logic [PROD_W-1:0]     product;
   logic [LIM_W-1:0]      limit;
   logic                  in_tol;
   logic                  grow;

   // Period, deviation from the known period and allowed deviation
   assign period  = count - prev_ff;
   assign diff    = (ref_ff >= period) ? (ref_ff - period) : (period - ref_ff);
   assign product = PROD_W'(cfg.tolerance_q15) * PROD_W'(ref_ff);
   assign limit   = product[PROD_W-1:Q15_SHIFT];
   assign in_tol  = LIM_W'(diff) <= limit;

   // Next state for one sample
   always_comb begin
      prev_in    = prev_ff;
      ref_in     = ref_ff;
      run_in     = run_ff;
      samples_in = samples_ff;
      verdict_in = verdict_ff;
      grow       = 1'b0;
      if (verdict_ff == VERDICT_MEASURING) begin
         prev_in = count;
         if (samples_ff != SAMPLE_MAX) begin
            samples_in = samples_ff + 1'b1;
         end
         if (run_ff == '0) begin
            ref_in = period;
            run_in = RUN_W'(1);
         end else if (in_tol) begin
            grow = 1'b1;
            if (run_ff != RUN_MAX) begin
               run_in = run_ff + 1'b1;
            end
         end else begin
            run_in = '0;
         end
         // growth check first, then the sample budget
         if (grow && (run_in >= RUN_W'(cfg.min_stable_run))) begin
            verdict_in = VERDICT_STABLE;
         end else if (samples_in >= cfg.max_samples) begin
            verdict_in = (run_in >= RUN_W'(cfg.min_stable_run)) ? VERDICT_STABLE
                                                                 : VERDICT_TIMEOUT;
         end
      end
   end

   // Result of this sample; period reads zero once the verdict is frozen
   always_comb begin
      res.verdict    = verdict_in;
      res.run_length = run_in;
      if (verdict_ff == VERDICT_MEASURING) begin
         res.measured_period = COUNT_W'(period);
      end else begin
         res.measured_period = '0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         ref_ff     <= '0;
         run_ff     <= '0;
         samples_ff <= '0;
         verdict_ff <= VERDICT_MEASURING;
      end else if (step) begin
         prev_ff    <= prev_in;
         ref_ff     <= ref_in;
         run_ff     <= run_in;
         samples_ff <= samples_in;
         verdict_ff <= verdict_in;
      end
   end

   // Once decided, the verdict never changes until reset
   a_verdict_sticky: assert property (@(posedge clock) disable iff (reset)
      (verdict_ff != VERDICT_MEASURING) |=> (verdict_ff == $past(verdict_ff)))
      else $error("verdict changed after being decided");

   // A run can never be longer than the number of samples seen
   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      RUN_W'(samples_ff) >= run_ff)
      else $error("run length exceeds sample count");

   // No sample means no state change
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(run_ff) && $stable(samples_ff) && $stable(prev_ff)))
      else $error("state moved without a sample");

   // A full sample count always comes with a decided verdict
   a_budget: assert property (@(posedge clock) disable iff (reset)
      (samples_ff == SAMPLE_MAX) |-> (verdict_ff != VERDICT_MEASURING))
      else $error("still measuring with the sample count full");

endmodule

/* hdl/crystal_stability_checker.sv */
// Crystal stability checker top level: CSR bank, input register, result register.
// Depends on csc_pkg, csc_req_if, csc_rsp_if and csc_core.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    timer_count[31:0]
//   rsp      out  valid/ready    verdict[1:0], run_length[8:0], measured_period[31:0]
//   csr      in   csr_wr_en      csr_index[1:0], csr_data[15:0]
//
// One sample per clock sustained while rsp is ready; a sample passes the input register
// and the combinational update into the result register, which drives rsp.
// The update is a 16x32 multiply and a compare on the registered state.
// Synchronous active-high reset clears all but data registers; no clearing pass is needed.
// A stall on rsp backs up through both registers to req.ready combinationally.
module crystal_stability_checker import csc_pkg::*; #(
   parameter int TIMER_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   csc_req_if.sink               req,
   csc_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type               cfg_ff;
   logic                  in_vld_ff;
   logic [TIMER_BITS-1:0] in_count_ff;
   logic                  out_vld_ff;
   result_type            out_ff;
   result_type            res;
   logic                  advance;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance_q15  <= TOLERANCE_RESET;
         cfg_ff.min_stable_run <= MIN_RUN_RESET;
         cfg_ff.max_samples    <= MAX_SAMPLE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOLERANCE:  cfg_ff.tolerance_q15  <= csr_data[TOL_W-1:0];
            CSR_MIN_RUN:    cfg_ff.min_stable_run <= csr_data[MIN_W-1:0];
            CSR_MAX_SAMPLE: cfg_ff.max_samples    <= csr_data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Input stage moves on when the result register is free or being emptied
   assign advance   = !out_vld_ff || rsp.ready;
   assign req.ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req.ready) begin
         in_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_count_ff <= req.timer_count[TIMER_BITS-1:0];
      end
   end

   csc_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .step  (in_vld_ff && advance),
      .count (in_count_ff),
      .res   (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_ff && advance) begin
         out_ff <= res;
      end
   end

   assign rsp.valid           = out_vld_ff;
   assign rsp.verdict         = out_ff.verdict;
   assign rsp.run_length      = out_ff.run_length;
   assign rsp.measured_period = out_ff.measured_period;

   // A held transaction on rsp must not be overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp.ready) |=> (out_vld_ff && $stable(out_ff)))
      else $error("stalled transaction lost");

   // A sample in the input register survives a stall
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_count_ff)))
      else $error("input sample lost while stalled");

   // Input side is never blocked while the result register is empty
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !out_vld_ff |-> req.ready)
      else $error("ready low with empty pipeline");

endmodule
